// File: src/cpl_pkg.sv
// ----------------------------------------------------------------------------
// Channel-position list parser package
// Shared widths and defaults for the parser, its channels and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cpl_pkg;

    localparam int DATA_W               = 8;
    localparam int SECTION_W            = 4;
    localparam int MAX_SECTIONS_DEFAULT = 16;

endpackage

`default_nettype wire

// File: src/cpl_ifs.sv
// ----------------------------------------------------------------------------
// Channel-position list parser channels
// Valid/ready channels for payload bytes in and parsed positions out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpl_byte_if;
    logic                        valid;
    logic                        ready;
    logic [cpl_pkg::DATA_W-1:0]  data_byte;
    logic                        end_of_payload;

    modport source (output valid, output data_byte, output end_of_payload, input ready);
    modport sink   (input valid, input data_byte, input end_of_payload, output ready);
endinterface

interface cpl_pos_if;
    logic                          valid;
    logic                          ready;
    logic                          position_valid;
    logic [cpl_pkg::SECTION_W-1:0] section_number;
    logic [cpl_pkg::DATA_W-1:0]    stream_position;
    logic [cpl_pkg::DATA_W-1:0]    section_location;
    logic                          payload_done;
    logic                          malformed;

    modport source (output valid, output position_valid, output section_number,
                    output stream_position, output section_location,
                    output payload_done, output malformed, input ready);
    modport sink   (input valid, input position_valid, input section_number,
                    input stream_position, input section_location,
                    input payload_done, input malformed, output ready);
endinterface

`default_nettype wire

// File: src/channel_position_list_parser.sv
// ----------------------------------------------------------------------------
// Channel-position list parser
// Parses a channel-position payload one byte per request and reports each
// well-formed (stream position, location) pair plus a done/malformed status.
// ----------------------------------------------------------------------------
//
//   Channel     Dir   Request carries
//   ---------   ---   ------------------------------------------------------
//   bytes       in    data_byte, end_of_payload
//   positions   out   position_valid, section_number, stream_position,
//                     section_location, payload_done, malformed
//
// One byte per cycle while the output is not stalled; a byte's result passes
// through the input register, then the result register, to the output.
// Bytes that complete no pair and do not end the payload give no request.
// Reset clears the parser state and empties both registers.
// A stalled output holds the parse stage and the input register; the byte
// side drops ready in the same cycle unless the input register is empty.
//
`default_nettype none

module channel_position_list_parser #(
    parameter int MAX_SECTIONS = cpl_pkg::MAX_SECTIONS_DEFAULT
) (
    input  wire          clk,
    input  wire          rst_n,
    cpl_byte_if.sink     bytes,
    cpl_pos_if.source    positions
);

    localparam int DW   = cpl_pkg::DATA_W;
    localparam int SW   = cpl_pkg::SECTION_W;
    localparam int SLW  = $clog2(MAX_SECTIONS + 1);

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_CHANNELS,
        PH_POSITION,
        PH_LOCATION
    } phase_t;

    // Input register
    logic            in_valid_reg;
    logic [DW-1:0]   in_byte_reg;
    logic            in_last_reg;

    // Parser state
    phase_t          phase_reg,         phase_next;
    logic [SLW-1:0]  sections_left_reg, sections_left_next;
    logic [SW-1:0]   cur_section_reg,   cur_section_next;
    logic [DW-1:0]   pairs_left_reg,    pairs_left_next;
    logic [DW-1:0]   held_pos_reg,      held_pos_next;
    logic            error_reg,         error_next;

    // Result register
    logic            out_valid_reg;
    logic            pos_valid_reg,  pos_valid_next;
    logic [SW-1:0]   section_reg,    section_next;
    logic [DW-1:0]   stream_pos_reg, stream_pos_next;
    logic [DW-1:0]   location_reg,   location_next;
    logic            done_reg,       done_next;
    logic            malformed_reg,  malformed_next;

    logic advance;
    logic emit;

    assign advance      = in_valid_reg && (!out_valid_reg || positions.ready);
    assign bytes.ready  = !in_valid_reg || advance;
    assign emit         = advance && (pos_valid_next || in_last_reg);

    always_comb
    begin
        phase_next         = phase_reg;
        sections_left_next = sections_left_reg;
        cur_section_next   = cur_section_reg;
        pairs_left_next    = pairs_left_reg;
        held_pos_next      = held_pos_reg;
        error_next         = error_reg;
        pos_valid_next     = 1'b0;
        section_next       = '0;
        stream_pos_next    = '0;
        location_next      = '0;
        done_next          = in_last_reg;
        malformed_next     = 1'b0;

        if (!error_reg)
        begin
            unique case (phase_reg)
                PH_COUNT:
                begin
                    if (in_byte_reg > DW'(MAX_SECTIONS))
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        sections_left_next = SLW'(in_byte_reg);
                        cur_section_next   = '0;
                        phase_next         = PH_CHANNELS;
                    end
                end
                PH_CHANNELS:
                begin
                    if (sections_left_reg == '0)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        pairs_left_next = in_byte_reg;
                        if (in_byte_reg == '0)
                        begin
                            sections_left_next = sections_left_reg - SLW'(1);
                            cur_section_next   = cur_section_reg + SW'(1);
                        end
                        else
                        begin
                            phase_next = PH_POSITION;
                        end
                    end
                end
                PH_POSITION:
                begin
                    held_pos_next = in_byte_reg;
                    phase_next    = PH_LOCATION;
                end
                PH_LOCATION:
                begin
                    if (held_pos_reg == '0 || in_byte_reg == '0)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        pos_valid_next  = 1'b1;
                        section_next    = cur_section_reg;
                        stream_pos_next = held_pos_reg - DW'(1);
                        location_next   = in_byte_reg - DW'(1);
                        pairs_left_next = pairs_left_reg - DW'(1);
                        // The section ends when its last pair is in.
                        if (pairs_left_reg == DW'(1))
                        begin
                            sections_left_next = sections_left_reg - SLW'(1);
                            cur_section_next   = cur_section_reg + SW'(1);
                            phase_next         = PH_CHANNELS;
                        end
                        else
                        begin
                            phase_next = PH_POSITION;
                        end
                    end
                end
                default:
                begin
                    error_next = 1'b1;
                end
            endcase
        end

        if (in_last_reg)
        begin
            malformed_next = error_next || (phase_next != PH_CHANNELS) ||
                             (sections_left_next != '0);
            phase_next         = PH_COUNT;
            sections_left_next = '0;
            cur_section_next   = '0;
            pairs_left_next    = '0;
            held_pos_next      = '0;
            error_next         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            in_byte_reg       <= '0;
            in_last_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_reg         <= PH_COUNT;
            sections_left_reg <= '0;
            cur_section_reg   <= '0;
            pairs_left_reg    <= '0;
            held_pos_reg      <= '0;
            error_reg         <= 1'b0;
            pos_valid_reg     <= 1'b0;
            section_reg       <= '0;
            stream_pos_reg    <= '0;
            location_reg      <= '0;
            done_reg          <= 1'b0;
            malformed_reg     <= 1'b0;
        end
        else
        begin
            if (bytes.ready)
            begin
                in_valid_reg <= bytes.valid;
            end

            if (bytes.ready && bytes.valid)
            begin
                in_byte_reg <= bytes.data_byte;
                in_last_reg <= bytes.end_of_payload;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (positions.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg         <= phase_next;
                sections_left_reg <= sections_left_next;
                cur_section_reg   <= cur_section_next;
                pairs_left_reg    <= pairs_left_next;
                held_pos_reg      <= held_pos_next;
                error_reg         <= error_next;
            end

            if (emit)
            begin
                pos_valid_reg  <= pos_valid_next;
                section_reg    <= section_next;
                stream_pos_reg <= stream_pos_next;
                location_reg   <= location_next;
                done_reg       <= done_next;
                malformed_reg  <= malformed_next;
            end
        end
    end

    assign positions.valid            = out_valid_reg;
    assign positions.position_valid   = pos_valid_reg;
    assign positions.section_number   = section_reg;
    assign positions.stream_position  = stream_pos_reg;
    assign positions.section_location = location_reg;
    assign positions.payload_done     = done_reg;
    assign positions.malformed        = malformed_reg;

endmodule

`default_nettype wire

// File: src/cpl_checker.sv
// ----------------------------------------------------------------------------
// Channel-position list parser checker
// Port-level properties of the parser's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cpl_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          out_valid,
    input wire                          out_ready,
    input wire                          position_valid,
    input wire [cpl_pkg::SECTION_W-1:0] section_number,
    input wire [cpl_pkg::DATA_W-1:0]    stream_position,
    input wire [cpl_pkg::DATA_W-1:0]    section_location,
    input wire                          payload_done,
    input wire                          malformed
);

    // Every request carries a pair, a done status, or both.
    a_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (position_valid || payload_done))
        else $error("result request with neither pair nor done");

    a_malformed_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !payload_done) |-> !malformed)
        else $error("malformed set without done");

    // Wire values are nonzero, so a decremented value never wraps to all ones.
    a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && position_valid) |->
            (stream_position != 8'hFF && section_location != 8'hFF))
        else $error("reported pair out of range");

    a_no_pair_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !position_valid) |->
            (section_number == '0 && stream_position == '0 && section_location == '0))
        else $error("pair fields nonzero on a done-only result");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(position_valid) && $stable(payload_done) &&
             $stable(malformed) && $stable(stream_position)))
        else $error("stalled result changed");

endmodule

bind channel_position_list_parser cpl_checker u_cpl_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (positions.valid),
    .out_ready        (positions.ready),
    .position_valid   (positions.position_valid),
    .section_number   (positions.section_number),
    .stream_position  (positions.stream_position),
    .section_location (positions.section_location),
    .payload_done     (positions.payload_done),
    .malformed        (positions.malformed)
);

`default_nettype wire
